[rtl/core/fixed_block_pool_allocator_core_assert.svh]
// Assertion macros shared by the allocator core modules.
// Each module that uses them has ports named i_clk and i_rst_n.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`endif

[rtl/core/fbpa_pkg.sv]
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int STRIDE_W       = 17;
    localparam int CFG_CNT_W      = 9;
    localparam int STAT_W         = 3;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int NUM_BLOCKS_DEF = 256;

    localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 17'd4;
    localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 17'd65536;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 17'd16;
    localparam logic [CFG_CNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID     = 3'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_POOL = 3'd2;
    localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    typedef struct packed {
        logic              alloc_pop;
        logic              alloc_mark;
        logic              load_res;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              free_setup;
        logic              div_start;
        logic              map_rd;
        logic              free_commit;
        logic              sweep_start;
        logic              sweep_step;
        logic              sweep_finish;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic empty;
        logic full;
        logic addr_zero;
        logic off_ge_lim;
        logic div_done;
        logic rem_nz;
        logic map_bit;
        logic sweep_last;
    } t_stat;

endpackage

[rtl/core/fixed_block_pool_allocator_core.sv]
`timescale 1ns / 1ps

// Fixed-size block pool allocator.
// A command is taken when start is high and busy is low. The opcode selects
// alloc, free (of i_block_address) or reinitialize. Exactly one result follows
// each command: o_done is high for one cycle with status, result address and
// the free and used block counts. The receiver cannot hold a result off.
// Free checks, in order, that the address is nonzero and the pool is ready,
// that it lies inside the pool, then runs the bit-serial divider (one quotient
// bit per cycle over 32 bits) to find it on a stride boundary with some block
// in use, and last reads the bitmap. Reinitialize sweeps the bitmap and stack
// memories one entry per cycle. Rejected alloc and unknown opcodes go straight
// to the result. The user must write the configuration registers through the
// write port only while the block is idle; the block itself does not enforce
// this. They take effect at once. After reset the pool is not ready: alloc and
// free report invalid until the first reinitialize transaction.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [ADDR_W-1:0]     i_block_address,
    output logic                  o_done,
    output logic [STAT_W-1:0]     o_status,
    output logic [ADDR_W-1:0]     o_result_address,
    output logic [CFG_CNT_W-1:0]  o_free_count,
    output logic [CFG_CNT_W-1:0]  o_used_blocks,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    fbpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    fbpa_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_block_address  (i_block_address),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_free_count     (o_free_count),
        .o_used_blocks    (o_used_blocks)
    );

endmodule

[rtl/core/fbpa_div.sv]
`timescale 1ns / 1ps

module fbpa_div
    import fbpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ADDR_W-1:0]   i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_quotient,
    output logic [STRIDE_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(ADDR_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ADDR_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [ADDR_W-1:0]   r_quo;
    logic [STRIDE_W-1:0] r_rem;
    logic [STRIDE_W-1:0] r_dvs;
    logic [STRIDE_W:0]   rem_sh;
    logic                take;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        rem_sh = {r_rem, r_quo[ADDR_W-1]};
        take   = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], take};
            r_rem <= take ? STRIDE_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[STRIDE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/core/fbpa_ctrl.sv]
`timescale 1ns / 1ps

`include "fixed_block_pool_allocator_core_assert.svh"

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_opcode,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_MARK = 4'd1;
    localparam logic [3:0] S_A_ADDR = 4'd2;
    localparam logic [3:0] S_F_CHK  = 4'd3;
    localparam logic [3:0] S_F_DIV  = 4'd4;
    localparam logic [3:0] S_F_RD   = 4'd5;
    localparam logic [3:0] S_SWEEP  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        OP_ALLOC: begin
                            if (!i_stat.ready) begin
                                o_cmd.set_status  = 1'b1;
                                o_cmd.status_code = ST_INVALID;
                                n_state           = S_DONE;
                            end else if (i_stat.empty) begin
                                o_cmd.set_status  = 1'b1;
                                o_cmd.status_code = ST_EMPTY;
                                n_state           = S_DONE;
                            end else begin
                                o_cmd.alloc_pop = 1'b1;
                                n_state         = S_A_MARK;
                            end
                        end
                        OP_FREE: begin
                            if (i_stat.addr_zero || !i_stat.ready) begin
                                o_cmd.set_status  = 1'b1;
                                o_cmd.status_code = ST_INVALID;
                                n_state           = S_DONE;
                            end else begin
                                o_cmd.free_setup = 1'b1;
                                n_state          = S_F_CHK;
                            end
                        end
                        OP_REINIT: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_SWEEP;
                        end
                        default: begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = ST_INVALID;
                            n_state           = S_DONE;
                        end
                    endcase
                end
            end
            S_A_MARK: begin
                o_cmd.alloc_mark = 1'b1;
                n_state          = S_A_ADDR;
            end
            S_A_ADDR: begin
                o_cmd.set_status  = 1'b1;
                o_cmd.status_code = ST_OK;
                o_cmd.load_res    = 1'b1;
                n_state           = S_DONE;
            end
            S_F_CHK: begin
                if (i_stat.off_ge_lim) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_OUT_OF_POOL;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_F_DIV;
                end
            end
            S_F_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_nz) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_OUT_OF_POOL;
                        n_state           = S_DONE;
                    end else if (i_stat.full) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_DOUBLE_FREE;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.map_rd = 1'b1;
                        n_state      = S_F_RD;
                    end
                end
            end
            S_F_RD: begin
                o_cmd.set_status = 1'b1;
                if (!i_stat.map_bit) begin
                    o_cmd.status_code = ST_DOUBLE_FREE;
                end else begin
                    o_cmd.status_code = ST_OK;
                    o_cmd.free_commit = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.sweep_finish = 1'b1;
                    o_cmd.set_status   = 1'b1;
                    o_cmd.status_code  = ST_OK;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    `FBPA_ASSERT_NXT(a_accept_leaves_idle, i_start && !o_busy, r_state != S_IDLE)
    `FBPA_ASSERT_NXT(a_done_returns_idle, r_state == S_DONE, r_state == S_IDLE)
    `FBPA_ASSERT_IMP(a_commit_needs_used, o_cmd.free_commit, i_stat.map_bit && i_stat.ready)

endmodule

[rtl/core/fbpa_dp.sv]
`timescale 1ns / 1ps

`include "fixed_block_pool_allocator_core_assert.svh"

module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_block_address,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [STAT_W-1:0]     o_status,
    output logic [ADDR_W-1:0]     o_result_address,
    output logic [CFG_CNT_W-1:0]  o_free_count,
    output logic [CFG_CNT_W-1:0]  o_used_blocks
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
    localparam int LIM_W  = STRIDE_W + CNT_W;
    localparam int OFF_W  = (LIM_W > ADDR_W) ? LIM_W : ADDR_W;
    localparam int PROD_W = IDX_W + STRIDE_W;

    logic [ADDR_W-1:0]    r_pool_base;
    logic [STRIDE_W-1:0]  r_block_stride;
    logic [CFG_CNT_W-1:0] r_block_count;

    logic [CNT_W-1:0]     r_free_total;
    logic                 r_ready;
    logic [IDX_W-1:0]     r_k;

    logic [ADDR_W-1:0]    r_off;
    logic [LIM_W-1:0]     r_limit;
    logic [PROD_W-1:0]    r_prod;
    logic [IDX_W-1:0]     r_idx;
    logic [STAT_W-1:0]    r_status;
    logic [ADDR_W-1:0]    r_res_addr;

    logic [IDX_W-1:0]     r_stack_mem [NUM_BLOCKS];
    logic [IDX_W-1:0]     r_stack_q;
    logic                 r_map_mem [NUM_BLOCKS];
    logic                 r_map_q;

    logic [STRIDE_W-1:0]  eff_stride;
    logic [CNT_W-1:0]     eff_count;
    logic [CMP_W-1:0]     cnt_raw;
    logic [CNT_W-1:0]     used_cnt;
    logic                 sweep_in;

    logic                 stack_we;
    logic [IDX_W-1:0]     stack_wa;
    logic [IDX_W-1:0]     stack_wd;
    logic [IDX_W-1:0]     stack_ra;
    logic                 map_we;
    logic [IDX_W-1:0]     map_wa;
    logic                 map_wd;

    logic                 div_done;
    logic [ADDR_W-1:0]    div_quo;
    logic [STRIDE_W-1:0]  div_rem;

    always_comb begin
        if (r_block_stride < STRIDE_MIN) begin
            eff_stride = STRIDE_MIN;
        end else if (r_block_stride > STRIDE_MAX) begin
            eff_stride = STRIDE_MAX;
        end else begin
            eff_stride = r_block_stride;
        end
        cnt_raw = CMP_W'(r_block_count);
        if (cnt_raw == '0) begin
            eff_count = CNT_W'(1);
        end else if (cnt_raw > CMP_W'(NUM_BLOCKS)) begin
            eff_count = CNT_W'(NUM_BLOCKS);
        end else begin
            eff_count = CNT_W'(cnt_raw);
        end
        used_cnt = (eff_count >= r_free_total) ? eff_count - r_free_total : '0;
        sweep_in = CNT_W'(r_k) < eff_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= '0;
            r_block_stride <= STRIDE_RESET;
            r_block_count  <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE:    r_pool_base    <= i_cfg_data[ADDR_W-1:0];
                CFG_BLOCK_STRIDE: r_block_stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_BLOCK_COUNT:  r_block_count  <= i_cfg_data[CFG_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_total <= '0;
            r_ready      <= 1'b0;
            r_k          <= '0;
        end else begin
            if (i_cmd.alloc_pop) begin
                r_free_total <= r_free_total - CNT_W'(1);
            end else if (i_cmd.free_commit) begin
                r_free_total <= r_free_total + CNT_W'(1);
            end else if (i_cmd.sweep_finish) begin
                r_free_total <= eff_count;
            end
            if (i_cmd.sweep_finish) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.sweep_start) begin
                r_k <= '0;
            end else if (i_cmd.sweep_step) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    // The stack holds block indices; the block on top is the last one pushed that has not been popped.
    always_comb begin
        stack_ra = IDX_W'(r_free_total - CNT_W'(1));
        stack_we = i_cmd.free_commit || (i_cmd.sweep_step && sweep_in);
        if (i_cmd.sweep_step) begin
            stack_wa = r_k;
            stack_wd = IDX_W'(eff_count - CNT_W'(1) - CNT_W'(r_k));
        end else begin
            stack_wa = r_free_total[IDX_W-1:0];
            stack_wd = r_idx;
        end
        map_we = i_cmd.alloc_mark || i_cmd.free_commit || i_cmd.sweep_step;
        if (i_cmd.sweep_step) begin
            map_wa = r_k;
            map_wd = 1'b0;
        end else if (i_cmd.alloc_mark) begin
            map_wa = r_stack_q;
            map_wd = 1'b1;
        end else begin
            map_wa = r_idx;
            map_wd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[stack_wa] <= stack_wd;
        end
        if (i_cmd.alloc_pop) begin
            r_stack_q <= r_stack_mem[stack_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (i_cmd.map_rd) begin
            r_map_q <= r_map_mem[div_quo[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.free_setup) begin
            r_off   <= i_block_address - r_pool_base;
            r_limit <= LIM_W'(eff_stride) * LIM_W'(eff_count);
        end
        if (i_cmd.alloc_mark) begin
            r_prod <= PROD_W'(r_stack_q) * PROD_W'(eff_stride);
        end
        if (i_cmd.map_rd) begin
            r_idx <= div_quo[IDX_W-1:0];
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.load_res) begin
            r_res_addr <= r_pool_base + ADDR_W'(r_prod);
        end else if (i_cmd.set_status) begin
            r_res_addr <= '0;
        end
    end

    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_off),
        .i_divisor   (eff_stride),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        o_stat.ready      = r_ready;
        o_stat.empty      = (r_free_total == '0);
        o_stat.full       = (r_free_total >= eff_count);
        o_stat.addr_zero  = (i_block_address == '0);
        o_stat.off_ge_lim = (OFF_W'(r_off) >= OFF_W'(r_limit));
        o_stat.div_done   = div_done;
        o_stat.rem_nz     = (div_rem != '0);
        o_stat.map_bit    = r_map_q;
        o_stat.sweep_last = (r_k == IDX_W'(NUM_BLOCKS - 1));
    end

    assign o_status         = r_status;
    assign o_result_address = r_res_addr;
    assign o_free_count     = CFG_CNT_W'(r_free_total);
    assign o_used_blocks    = CFG_CNT_W'(used_cnt);

    `FBPA_ASSERT_IMP(a_pop_needs_block, i_cmd.alloc_pop, r_free_total != '0)
    `FBPA_ASSERT_NXT(a_sweep_fills_stack, i_cmd.sweep_finish, r_ready && (r_free_total == eff_count))

endmodule

[dv/fbpa_pool_checker.sv]
`timescale 1ns / 1ps

module fbpa_pool_checker
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [ADDR_W-1:0]     i_block_address,
    input  logic                  i_done,
    input  logic [STAT_W-1:0]     i_status,
    input  logic [ADDR_W-1:0]     i_result_address,
    input  logic [CFG_CNT_W-1:0]  i_free_count,
    input  logic [CFG_CNT_W-1:0]  i_used_blocks,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    address;
        logic [CFG_CNT_W-1:0] free_cnt;
        logic [CFG_CNT_W-1:0] used_cnt;
    } t_pool_reply;

    logic [ADDR_W-1:0]    base_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [CFG_CNT_W-1:0] count_reg;

    logic [IDX_W-1:0] free_stack [NUM_BLOCKS];
    logic             used_map   [NUM_BLOCKS];
    int unsigned      free_total;
    bit               pool_ready;

    t_pool_reply queued_replies [$];
    int          mismatch_total = 0;
    int          pending_total  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_total;

    function automatic int unsigned stride_in_use();
        if (stride_reg < STRIDE_MIN) return STRIDE_MIN;
        if (stride_reg > STRIDE_MAX) return STRIDE_MAX;
        return stride_reg;
    endfunction

    function automatic int unsigned count_in_use();
        if (count_reg == 0) return 1;
        if (count_reg > NUM_BLOCKS) return NUM_BLOCKS;
        return count_reg;
    endfunction

    function automatic t_pool_reply apply_pool_command(input logic [OP_W-1:0] op,
                                                       input logic [ADDR_W-1:0] addr);
        t_pool_reply       r;
        int unsigned       stride;
        int unsigned       count;
        int unsigned       idx;
        logic [ADDR_W-1:0] off;
        longint unsigned   span;
        stride   = stride_in_use();
        count    = count_in_use();
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (!pool_ready) begin
                    r.status = ST_INVALID;
                end else if (free_total == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_total--;
                    idx = free_stack[free_total];
                    used_map[idx] = 1'b1;
                    r.address = base_reg + ADDR_W'(idx * stride);
                end
            end
            OP_FREE: begin
                off  = addr - base_reg;
                span = longint'(stride) * count;
                if (addr == '0 || !pool_ready) begin
                    r.status = ST_INVALID;
                end else if (off >= span || off % stride != 0) begin
                    r.status = ST_OUT_OF_POOL;
                end else if (free_total >= count) begin
                    r.status = ST_DOUBLE_FREE;
                end else begin
                    idx = off / stride;
                    if (idx >= NUM_BLOCKS || !used_map[idx]) begin
                        r.status = ST_DOUBLE_FREE;
                    end else begin
                        used_map[idx] = 1'b0;
                        free_stack[free_total] = IDX_W'(idx);
                        free_total++;
                    end
                end
            end
            OP_REINIT: begin
                for (int k = 0; k < NUM_BLOCKS; k++) used_map[k] = 1'b0;
                for (int k = 0; k < count; k++) free_stack[k] = IDX_W'(count - 1 - k);
                free_total = count;
                pool_ready = 1'b1;
            end
            default: r.status = ST_INVALID;
        endcase
        r.free_cnt = CFG_CNT_W'(free_total);
        r.used_cnt = (count >= free_total) ? CFG_CNT_W'(count - free_total) : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pool_reply want;
        if (!i_rst_n) begin
            base_reg   = '0;
            stride_reg = STRIDE_RESET;
            count_reg  = COUNT_RESET;
            free_total = 0;
            pool_ready = 1'b0;
            for (int k = 0; k < NUM_BLOCKS; k++) used_map[k] = 1'b0;
            queued_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:    base_reg   = i_cfg_data[ADDR_W-1:0];
                    CFG_BLOCK_STRIDE: stride_reg = i_cfg_data[STRIDE_W-1:0];
                    CFG_BLOCK_COUNT:  count_reg  = i_cfg_data[CFG_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (queued_replies.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    mismatch_total++;
                end else begin
                    want = queued_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        mismatch_total++;
                    end
                    if (i_result_address !== want.address) begin
                        $error("result_address: expected %08h, got %08h",
                               want.address, i_result_address);
                        mismatch_total++;
                    end
                    if (i_free_count !== want.free_cnt) begin
                        $error("free_count: expected %0d, got %0d", want.free_cnt, i_free_count);
                        mismatch_total++;
                    end
                    if (i_used_blocks !== want.used_cnt) begin
                        $error("used_blocks: expected %0d, got %0d", want.used_cnt, i_used_blocks);
                        mismatch_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                queued_replies.push_back(apply_pool_command(i_opcode, i_block_address));
            end
        end
        pending_total = queued_replies.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fbpa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SEGMENTS  = 4;
    localparam int SEG_ITEMS = 65;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_opcode;
    logic [ADDR_W-1:0]     i_block_address;
    logic                  o_done;
    logic [STAT_W-1:0]     o_status;
    logic [ADDR_W-1:0]     o_result_address;
    logic [CFG_CNT_W-1:0]  o_free_count;
    logic [CFG_CNT_W-1:0]  o_used_blocks;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int idle_pct;

    logic [ADDR_W-1:0] cur_base;
    int unsigned       cur_stride;
    int unsigned       cur_count;

    fixed_block_pool_allocator_core #(
        .NUM_BLOCKS(NUM_BLOCKS_DEF)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_block_address  (i_block_address),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_free_count     (o_free_count),
        .o_used_blocks    (o_used_blocks),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    fbpa_pool_checker #(
        .NUM_BLOCKS(NUM_BLOCKS_DEF)
    ) pool_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_block_address  (i_block_address),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_result_address (o_result_address),
        .i_free_count     (o_free_count),
        .i_used_blocks    (o_used_blocks),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_block_address <= addr;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [31:0] stride_raw,
                             input logic [31:0] count_raw);
        int unsigned s;
        int unsigned c;
        s = stride_raw[STRIDE_W-1:0];
        c = count_raw[CFG_CNT_W-1:0];
        settle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_BLOCK_STRIDE, stride_raw);
        write_reg(CFG_BLOCK_COUNT, count_raw);
        cur_base   = base;
        cur_stride = (s < STRIDE_MIN) ? STRIDE_MIN : (s > STRIDE_MAX) ? STRIDE_MAX : s;
        cur_count  = (c == 0) ? 1 : (c > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : c;
    endtask

    task automatic pick_config(input int g);
        logic [ADDR_W-1:0] base;
        logic [31:0]       stride_raw;
        logic [31:0]       count_raw;
        case (g)
            0: configure('0, 0, 0);
            1: configure('1, 131071, 511);
            2: configure(32'hFFFF_0000, STRIDE_MAX, 256);
            3: configure(32'h0000_1000, 3, 1);
            default: begin
                case ($urandom_range(3))
                    0: base = '0;
                    1: base = $urandom;
                    2: base = 32'hFFFF_FFFF - $urandom_range(4095);
                    default: base = $urandom & 32'hFFFF_F000;
                endcase
                case ($urandom_range(5))
                    0: stride_raw = $urandom_range(3);
                    1, 2: stride_raw = $urandom_range(4, 64);
                    3: stride_raw = $urandom_range(4, 65536);
                    4: stride_raw = $urandom_range(65537, 131071);
                    default: stride_raw = $urandom;
                endcase
                case ($urandom_range(5))
                    0: count_raw = 0;
                    1, 2, 3: count_raw = $urandom_range(1, 16);
                    4: count_raw = $urandom_range(17, 256);
                    default: count_raw = $urandom_range(257, 511);
                endcase
                configure(base, stride_raw, count_raw);
            end
        endcase
        if (g < 4 || $urandom_range(99) < 85) issue(OP_REINIT, $urandom);
    endtask

    task automatic run_segment(input int n_items, input int alloc_pct);
        int r;
        int unsigned idx;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < alloc_pct) begin
                issue(OP_ALLOC, $urandom);
            end else begin
                r = $urandom_range(99);
                if (r < 78) begin
                    idx = $urandom_range(cur_count);
                    issue(OP_FREE, cur_base + ADDR_W'(idx * cur_stride));
                end else if (r < 86) begin
                    idx = $urandom_range(cur_count - 1);
                    issue(OP_FREE, cur_base + ADDR_W'(idx * cur_stride)
                                   + ADDR_W'($urandom_range(1, cur_stride - 1)));
                end else if (r < 92) begin
                    issue(OP_FREE, $urandom);
                end else if (r < 97) begin
                    issue(OP_REINIT, $urandom);
                end else begin
                    issue(OP_UNUSED, $urandom);
                end
            end
            if ($urandom_range(99) == 0) settle();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_ALLOC;
        i_block_address = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_POOL_BASE;
        i_cfg_data      = '0;
        idle_pct        = 36;
        cur_base        = '0;
        cur_stride      = STRIDE_RESET;
        cur_count       = COUNT_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The pool is not ready until the first reinitialize.
        issue(OP_ALLOC, 32'h0);
        issue(OP_FREE, 32'h40);
        issue(OP_UNUSED, 32'hFFFF_FFFF);
        issue(OP_REINIT, 32'h0);
        issue(OP_FREE, 32'h0);
        issue(OP_FREE, 32'h10);
        issue(OP_ALLOC, 32'h0);
        issue(OP_ALLOC, 32'h0);
        issue(OP_FREE, 32'h8);
        issue(OP_FREE, 32'h1000);
        issue(OP_FREE, 32'h10);
        issue(OP_FREE, 32'h10);
        issue(OP_FREE, 32'hFFFF_FFF0);

        // A pool that wraps past the top of the address space.
        configure(32'hFFFF_FFE0, 16, 4);
        issue(OP_REINIT, 32'h0);
        repeat (5) issue(OP_ALLOC, 32'h0);
        issue(OP_FREE, 32'h0);
        issue(OP_FREE, 32'h10);
        issue(OP_FREE, 32'hFFFF_FFE0);
        issue(OP_FREE, 32'hFFFF_FFFF);
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                pick_config(phase * SEGMENTS + seg);
                run_segment(SEG_ITEMS, $urandom_range(30, 60));
            end
        end

        settle();
        repeat (NUM_BLOCKS_DEF + 16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_div.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dp.sv
rtl/core/fixed_block_pool_allocator_core.sv
dv/fbpa_pool_checker.sv
dv/tb.sv
